// File: design/wbps_pkg.sv
package wbps_pkg;

  localparam int MAX_PATTERN_BYTES = 16;
  localparam int REG_PATTERN_BYTES = 16;
  localparam int WIN_DEPTH = (MAX_PATTERN_BYTES < REG_PATTERN_BYTES) ?
                             MAX_PATTERN_BYTES : REG_PATTERN_BYTES;
  localparam int SLOT_W = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

  localparam int BYTE_W     = 8;
  localparam int LEN_W      = 5;
  localparam int MASK_W     = 16;
  localparam int ADDR_W     = 32;
  localparam int COUNT_W    = 32;
  localparam int PAT_WORD_W = 64;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  localparam logic STATUS_FOUND     = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_LOW     = 3'd0,
    REG_PAT_HIGH    = 3'd1,
    REG_WILD_MASK   = 3'd2,
    REG_PAT_LEN     = 3'd3,
    REG_REGION_BASE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              region_start;
    logic              region_end;
  } in_item_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] match_address;
  } out_item_t;

  typedef struct packed {
    logic [2*PAT_WORD_W-1:0] pattern;
    logic [MASK_W-1:0]       wild_mask;
    logic [LEN_W-1:0]        pat_len;
    logic [ADDR_W-1:0]       region_base;
  } cfg_t;

endpackage

// File: design/wildcard_byte_pattern_scanner.sv
// A result is registered in the output stage, or the skid stage while out_* stalls.
// One byte per cycle unless stalled; shift and full-signature compare are combinational.
// in_ready drops only while a result sits in the skid stage behind a stalled output.
// Reset: synchronous, active low; clears the byte count, scan-done flag, valid flags and
// configuration (pattern length to 1); window and result data registers are not reset.
module wildcard_byte_pattern_scanner (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  wbps_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output wbps_pkg::out_item_t            out_data,
  input  logic                           cfg_wr_en,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wbps_pkg::*;

  cfg_t      cfg;
  logic      in_fire;
  logic      res_valid;
  out_item_t res_item;

  assign in_fire = in_valid && in_ready;

  wbps_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  wbps_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_item   (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  wbps_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_item  (res_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .in_ready  (in_ready)
  );

endmodule

// File: design/wbps_cfg.sv
module wbps_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output wbps_pkg::cfg_t                 cfg
);
  import wbps_pkg::*;

  logic [PAT_WORD_W-1:0] pat_low_r;
  logic [PAT_WORD_W-1:0] pat_high_r;
  logic [MASK_W-1:0]     wild_mask_r;
  logic [LEN_W-1:0]      pat_len_r;
  logic [ADDR_W-1:0]     region_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r     <= '0;
      pat_high_r    <= '0;
      wild_mask_r   <= '0;
      pat_len_r     <= LEN_W'(1);
      region_base_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_PAT_LOW:     pat_low_r     <= cfg_wdata[PAT_WORD_W-1:0];
        REG_PAT_HIGH:    pat_high_r    <= cfg_wdata[PAT_WORD_W-1:0];
        REG_WILD_MASK:   wild_mask_r   <= cfg_wdata[MASK_W-1:0];
        REG_PAT_LEN:     pat_len_r     <= cfg_wdata[LEN_W-1:0];
        REG_REGION_BASE: region_base_r <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.pattern     = {pat_high_r, pat_low_r};
  assign cfg.wild_mask   = wild_mask_r;
  assign cfg.pat_len     = pat_len_r;
  assign cfg.region_base = region_base_r;

endmodule

// File: design/wbps_scan.sv
module wbps_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  wbps_pkg::in_item_t  in_item,
  input  wbps_pkg::cfg_t      cfg,
  output logic                res_valid,
  output wbps_pkg::out_item_t res_item
);
  import wbps_pkg::*;

  logic [BYTE_W-1:0]  win_r   [WIN_DEPTH];
  logic [BYTE_W-1:0]  win_nxt [WIN_DEPTH];
  logic [COUNT_W-1:0] seen_r;
  logic [COUNT_W-1:0] seen_nxt;
  logic               done_r;
  logic               skip;
  logic               hit;
  logic [LEN_W-1:0]   len_eff;

  // Window slots older than the region are never compared: a match needs
  // seen >= len, so only slots written in this region are read.
  always_comb begin
    logic [COUNT_W-1:0] seen_base;
    logic [LEN_W-1:0]   slot;
    skip = done_r && !in_item.region_start;

    win_nxt[0] = in_item.data_byte;
    for (int k = 1; k < WIN_DEPTH; k++) begin
      win_nxt[k] = win_r[k-1];
    end

    seen_base = in_item.region_start ? '0 : seen_r;
    seen_nxt  = (seen_base == '1) ? seen_base : seen_base + COUNT_W'(1);

    if (cfg.pat_len == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg.pat_len > LEN_W'(WIN_DEPTH)) begin
      len_eff = LEN_W'(WIN_DEPTH);
    end else begin
      len_eff = cfg.pat_len;
    end

    hit = (seen_nxt >= COUNT_W'(len_eff));
    for (int i = 0; i < WIN_DEPTH; i++) begin
      slot = len_eff - LEN_W'(i + 1);
      if ((LEN_W'(i) < len_eff) && !cfg.wild_mask[i] &&
          (win_nxt[slot[SLOT_W-1:0]] != cfg.pattern[BYTE_W*i +: BYTE_W])) begin
        hit = 1'b0;
      end
    end

    res_valid = in_fire && !skip && (hit || in_item.region_end);
    if (hit) begin
      res_item.status        = STATUS_FOUND;
      res_item.match_address = cfg.region_base + seen_nxt - ADDR_W'(len_eff);
    end else begin
      res_item.status        = STATUS_NOT_FOUND;
      res_item.match_address = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !skip) begin
      for (int k = 0; k < WIN_DEPTH; k++) begin
        win_r[k] <= win_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      done_r <= 1'b0;
    end else if (in_fire && !skip) begin
      seen_r <= seen_nxt;
      done_r <= res_valid;
    end
  end

endmodule

// File: design/wbps_outbuf.sv
module wbps_outbuf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  wbps_pkg::out_item_t res_item,
  input  logic                out_ready,
  output logic                out_valid,
  output wbps_pkg::out_item_t out_data,
  output logic                in_ready
);
  import wbps_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_item;
    end else if (res_valid) begin
      skid_data_r <= res_item;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign in_ready  = !skid_valid_r;

endmodule

// File: design/wbps_checker.sv
module wbps_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input wbps_pkg::out_item_t out_data
);
  import wbps_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == STATUS_NOT_FOUND) |-> out_data.match_address == '0)
    else $error("not-found result with nonzero address");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result without input transaction");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind wildcard_byte_pattern_scanner wbps_checker u_wbps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: test/tb_wildcard_byte_pattern_scanner.sv
module tb_wildcard_byte_pattern_scanner;
  import wbps_pkg::*;

  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 150;
  localparam int WATCHDOG_LIMIT = 3000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_data;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wildcard_byte_pattern_scanner dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // scanner shadow state and signature setup
  logic [7:0]        win_q [WIN_DEPTH];
  logic [COUNT_W-1:0] seen_q;
  bit                done_q;
  logic [63:0]       pat_lo, pat_hi;
  logic [15:0]       wmask;
  logic [4:0]        plen;
  logic [31:0]       base_q;

  out_item_t results_due [$];
  out_item_t due;

  int send_idle_pct, recv_idle_pct;
  int hold_serial, hold_seen, hold_left;
  int errors, quiet_cycles;
  int n_bytes, n_scanned, n_setups, n_found, n_missed;

  function automatic logic [7:0] pattern_byte(input int k);
    if (k < 8) return pat_lo[k*8 +: 8];
    return pat_hi[(k-8)*8 +: 8];
  endfunction

  function automatic int active_length();
    if (plen == 0) return 1;
    if (plen > WIN_DEPTH) return WIN_DEPTH;
    return int'(plen);
  endfunction

  function automatic bit scan_byte(input in_item_t item, output out_item_t res);
    int len, k;
    bit hit;
    res = '0;
    if (item.region_start) begin
      for (k = 0; k < WIN_DEPTH; k++) win_q[k] = '0;
      seen_q = '0;
      done_q = 1'b0;
    end
    if (done_q) return 1'b0;
    n_scanned++;
    for (k = WIN_DEPTH - 1; k > 0; k--) win_q[k] = win_q[k-1];
    win_q[0] = item.data_byte;
    if (seen_q != '1) seen_q++;
    len = active_length();
    hit = (seen_q >= COUNT_W'(len));
    for (k = 0; k < len; k++) begin
      if (!wmask[k] && win_q[len-1-k] != pattern_byte(k)) hit = 1'b0;
    end
    if (hit) begin
      res.status = STATUS_FOUND;
      res.match_address = base_q + seen_q - 32'(len);
      done_q = 1'b1;
      return 1'b1;
    end
    if (item.region_end) begin
      res.status = STATUS_NOT_FOUND;
      res.match_address = '0;
      done_q = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] data, input logic first, input logic last);
    in_item_t item;
    out_item_t res;
    item.data_byte = data;
    item.region_start = first;
    item.region_end = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_bytes++;
    if (scan_byte(item, res)) results_due.push_back(res);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_PAT_LOW:     pat_lo = val;
      REG_PAT_HIGH:    pat_hi = val;
      REG_WILD_MASK:   wmask = val[15:0];
      REG_PAT_LEN:     plen = val[4:0];
      REG_REGION_BASE: base_q = val[31:0];
      default: ;
    endcase
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_setup();
    logic [63:0] lo, hi;
    logic [15:0] m;
    logic [4:0]  len;
    logic [31:0] base;
    int pick;
    pick = $urandom_range(9);
    lo = {$urandom(), $urandom()};
    hi = {$urandom(), $urandom()};
    if (pick == 0) begin
      lo = '0;
      hi = '0;
    end else if (pick == 1) begin
      lo = '1;
      hi = '1;
    end
    case ($urandom_range(9))
      0: len = 5'd0;
      1: len = 5'($urandom_range(17, 31));
      2: len = 5'd16;
      3, 4: len = 5'($urandom_range(9, 16));
      default: len = 5'($urandom_range(1, 8));
    endcase
    case ($urandom_range(9))
      0, 1, 2: m = '0;
      3: m = '1;
      default: m = 16'($urandom() & $urandom());
    endcase
    case ($urandom_range(9))
      0: base = '0;
      1: base = 32'hFFFF_FFFF - 32'($urandom_range(20));
      default: base = $urandom();
    endcase
    cfg_write(REG_PAT_LOW, lo);
    cfg_write(REG_PAT_HIGH, hi);
    cfg_write(REG_WILD_MASK, {32'($urandom()), 16'($urandom()), m});
    cfg_write(REG_PAT_LEN, {32'($urandom()), 27'($urandom()), len});
    cfg_write(REG_REGION_BASE, {32'($urandom()), base});
    n_setups++;
  endtask

  // default setup: signature is one zero byte
  task automatic test_bytes_before_region_start();
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b1, 1'b1);
  endtask

  // overlapping candidate, match on last byte, address wraps past 2^32
  task automatic test_overlap_and_wrap();
    cfg_write(REG_PAT_LOW, 64'h0000_0000_00AB_AAAA);
    cfg_write(REG_PAT_LEN, 64'd3);
    cfg_write(REG_REGION_BASE, 64'hFFFF_FFFF);
    send_byte(8'hAA, 1'b1, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'hAA, 1'b0, 1'b0);
    send_byte(8'hAB, 1'b0, 1'b1);
  endtask

  // length above 16 saturates; wildcards at both ends of a full window
  task automatic test_full_width_signature();
    int k;
    cfg_write(REG_PAT_LOW, 64'h0);
    cfg_write(REG_PAT_HIGH, '1);
    cfg_write(REG_WILD_MASK, 64'h8001);
    cfg_write(REG_PAT_LEN, 64'd31);
    cfg_write(REG_REGION_BASE, 64'h1000);
    for (k = 0; k < 16; k++) begin
      send_byte((k == 0) ? 8'h5C : (k == 15) ? 8'h3E : (k < 8) ? 8'h00 : 8'hFF,
                k == 0, k == 15);
    end
  endtask

  // length zero acts as one; mask bits above the length are ignored
  task automatic test_zero_length();
    cfg_write(REG_PAT_LOW, 64'h5A);
    cfg_write(REG_WILD_MASK, 64'hFFFE);
    cfg_write(REG_PAT_LEN, 64'd0);
    cfg_write(REG_REGION_BASE, 64'h0);
    send_byte(8'h5B, 1'b1, 1'b0);
    send_byte(8'h5A, 1'b0, 1'b1);
  endtask

  // receiver stalls while every byte produces a result
  task automatic test_result_backpressure();
    int k;
    cfg_write(REG_WILD_MASK, 64'h1);
    cfg_write(REG_PAT_LEN, 64'd1);
    hold_serial++;
    for (k = 0; k < 30; k++) send_byte(8'($urandom()), 1'b1, 1'($urandom_range(1)));
    wait_drained();
  endtask

  task automatic test_random_regions(input int n_items);
    logic [7:0] region_bytes [$];
    int target, rlen, elen, at, k;
    target = n_bytes + n_items;
    random_setup();
    while (n_bytes < target) begin
      if ($urandom_range(5) == 0) random_setup();
      rlen = ($urandom_range(9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      elen = active_length();
      region_bytes.delete();
      for (k = 0; k < rlen; k++) begin
        region_bytes.push_back($urandom_range(1) ? pattern_byte($urandom_range(elen - 1))
                                                 : 8'($urandom()));
      end
      if ($urandom_range(9) < 6) begin
        at = $urandom_range(rlen - 1);
        for (k = 0; k < elen && at + k < rlen; k++) begin
          if (!wmask[k]) region_bytes[at+k] = pattern_byte(k);
        end
      end
      for (k = 0; k < rlen; k++) begin
        send_byte(region_bytes[k],
                  (k == 0) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0),
                  (k == rlen - 1) ? ($urandom_range(19) != 0) : ($urandom_range(49) == 0));
      end
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_serial != hold_seen) begin
        hold_seen = hold_serial;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("unexpected result transaction: status %0d, match_address %h",
               out_data.status, out_data.match_address);
        errors++;
      end else begin
        due = results_due.pop_front();
        if (out_data.status !== due.status) begin
          $error("status: expected %0d, actual %0d", due.status, out_data.status);
          errors++;
        end
        if (out_data.match_address !== due.match_address) begin
          $error("match_address: expected %h, actual %h",
                 due.match_address, out_data.match_address);
          errors++;
        end
        if (due.status == STATUS_FOUND) n_found++;
        else n_missed++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_wr_en <= 1'b0;
    cfg_index <= REG_PAT_LOW;
    cfg_wdata <= '0;
    for (int k = 0; k < WIN_DEPTH; k++) win_q[k] = '0;
    seen_q = '0;
    done_q = 1'b0;
    pat_lo = '0;
    pat_hi = '0;
    wmask  = '0;
    plen   = 5'd1;
    base_q = '0;
    send_idle_pct = 21;
    recv_idle_pct = 88;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_bytes_before_region_start();
    test_overlap_and_wrap();
    test_full_width_signature();
    test_zero_length();
    test_random_regions(450);

    send_idle_pct = 88;
    recv_idle_pct = 21;
    test_random_regions(450);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_result_backpressure();
    test_random_regions(450);

    wait_drained();
    $display("Scanned %0d bytes (%0d entered the window) under %0d random signature setups",
             n_bytes, n_scanned, n_setups);
    $display("Checked %0d match and %0d no-match results", n_found, n_missed);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
